[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold at the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcl_tok_pkg.sv]
package tcl_tok_pkg;

    localparam int LINE_W      = 20;
    localparam int CHAR_W      = 8;
    localparam int NEST_DEPTH  = 64;
    localparam int DEPTH_W     = $clog2(NEST_DEPTH + 1);
    localparam int SADDR_W     = $clog2(NEST_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINE_W-1:0] START_LINE_RST = LINE_W'(1);

    // Source bytes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7f;
    localparam logic [CHAR_W-1:0] CH_SP     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BSL    = 8'h5c;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_DQ     = 8'h22;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5b;
    localparam logic [CHAR_W-1:0] CH_RBRK   = 8'h5d;

    // Delimiter that closes the current token
    typedef enum logic [2:0] {
        DM_NONE,
        DM_SPACE,
        DM_COMMENT,
        DM_QUOTE,
        DM_BRACE,
        DM_SQUARE
    } t_delim;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_TOKEND,
        KIND_STMT,
        KIND_EOI
    } t_kind;

    // One result word
    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  ch;
        logic [LINE_W-1:0]  line;
    } t_res;

    // All results of one source byte (one or two)
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_pair;

endpackage

[rtl/tcl_tok_front.sv]
module tcl_tok_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_cmd,
    input  logic [tcl_tok_pkg::CHAR_W-1:0]  i_char,
    input  logic                            i_cfg_wr_en,
    input  logic [tcl_tok_pkg::LINE_W-1:0]  i_cfg_wr_data,
    output logic                            o_push,
    output tcl_tok_pkg::t_pair              o_pair
);
    import tcl_tok_pkg::*;

    // Tokenizer state
    t_delim              r_delim, n_delim;
    logic                r_eat, n_eat;
    logic                r_esc, n_esc;
    logic [DEPTH_W-1:0]  r_brace, n_brace;
    logic [DEPTH_W-1:0]  r_brk, n_brk;
    logic                r_qpar, n_qpar;
    logic                r_tnz, n_tnz;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [LINE_W-1:0]   r_tsl, n_tsl;
    logic [LINE_W-1:0]   r_start, n_start;

    // Bracket quote stack: memory plus cached top and prefetched entry below it
    logic                mem_stk [NEST_DEPTH];
    logic                r_top, n_top;
    logic                r_below;
    logic                stk_push;
    logic [SADDR_W-1:0]  stk_rd_addr;

    logic                res_cnt_nz;
    logic                res_two;
    t_res                res0, res1;

    // Next state and results for the accepted word
    always_comb begin
        t_delim             d;
        logic [DEPTH_W-1:0] nb;
        logic               tok_rst;
        logic               c_blank;

        n_delim  = r_delim;
        n_eat    = r_eat;
        n_esc    = r_esc;
        n_brace  = r_brace;
        n_brk    = r_brk;
        n_qpar   = r_qpar;
        n_tnz    = r_tnz;
        n_line   = r_line;
        n_tsl    = r_tsl;
        n_start  = r_start;
        n_top    = r_top;
        stk_push = 1'b0;
        res_cnt_nz = 1'b0;
        res_two  = 1'b0;
        res0     = '{kind: KIND_BYTE, ch: i_char, line: '0};
        res1     = '{kind: KIND_BYTE, ch: i_char, line: '0};
        tok_rst  = 1'b0;
        d        = r_delim;
        nb       = r_brk;
        c_blank  = (i_char == CH_SP) || (i_char == CH_TAB);

        if (i_accept) begin
            if (i_cmd) begin
                // end of code: close open token, then end of input
                res_cnt_nz = 1'b1;
                if (r_tnz) begin
                    res_two = 1'b1;
                    res0 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                    res1 = '{kind: KIND_EOI, ch: '0, line: r_tsl};
                end else begin
                    res0 = '{kind: KIND_EOI, ch: '0, line: r_tsl};
                end
                n_line  = r_start;
                tok_rst = 1'b1;
            end else if ((r_eat && c_blank) || (i_char == CH_DEL)) begin
                // dropped byte
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_char == CH_NL) begin
                    n_line = r_line + 1'b1;
                    if (r_eat) begin
                        n_delim = DM_NONE;
                        n_tsl   = r_line + 1'b1;
                    end else if (r_delim == DM_SPACE) begin
                        res_cnt_nz = 1'b1;
                        res0 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                        tok_rst = 1'b1;
                    end else begin
                        res_cnt_nz = 1'b1;
                        res_two = 1'b1;
                        res0.ch = CH_BSL;
                        n_tnz = 1'b1;
                    end
                end else begin
                    res_cnt_nz = 1'b1;
                    res_two = 1'b1;
                    res0.ch = CH_BSL;
                    n_tnz = 1'b1;
                    n_eat = 1'b0;
                end
            end else if (i_char == CH_BSL) begin
                n_esc = 1'b1;
                if (r_delim == DM_NONE) begin
                    n_delim = DM_SPACE;
                end
            end else begin
                n_eat = 1'b0;
                // most branches emit the byte itself
                res_cnt_nz = 1'b1;
                n_tnz = 1'b1;
                if (r_delim == DM_COMMENT && i_char != CH_NL) begin
                    // comment text passes through
                end else begin
                    case (i_char)
                        CH_HASH: begin
                            if (!r_tnz) begin
                                n_delim = DM_COMMENT;
                            end
                        end
                        CH_NL, CH_SEMI: begin
                            if (i_char == CH_NL) begin
                                n_line = r_line + 1'b1;
                            end
                            if (r_delim == DM_NONE || r_delim == DM_SPACE ||
                                r_delim == DM_COMMENT) begin
                                tok_rst = 1'b1;
                                if (r_delim != DM_NONE && r_tnz) begin
                                    res_two = 1'b1;
                                    res0 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                                    res1 = '{kind: KIND_STMT, ch: '0, line: r_tsl};
                                end else begin
                                    res0 = '{kind: KIND_STMT, ch: '0, line: r_tsl};
                                end
                            end
                        end
                        CH_SP, CH_TAB: begin
                            if (r_delim == DM_SPACE) begin
                                res0 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                                tok_rst = 1'b1;
                            end
                        end
                        CH_DQ: begin
                            n_qpar = ~r_qpar;
                            if (r_delim == DM_NONE) begin
                                n_delim = DM_QUOTE;
                            end else if (r_delim == DM_QUOTE) begin
                                res_two = 1'b1;
                                res1 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                                tok_rst = 1'b1;
                            end
                        end
                        CH_LBRACE: begin
                            d = (r_delim == DM_NONE) ? DM_BRACE : r_delim;
                            n_delim = d;
                            if (d == DM_BRACE && r_brace < DEPTH_W'(NEST_DEPTH)) begin
                                n_brace = r_brace + 1'b1;
                            end
                        end
                        CH_RBRACE: begin
                            if (r_delim == DM_NONE) begin
                                n_delim = DM_SPACE;
                            end else if (r_delim == DM_BRACE) begin
                                nb = (r_brace != '0) ? r_brace - 1'b1 : r_brace;
                                n_brace = nb;
                                if (nb == '0) begin
                                    res_two = 1'b1;
                                    res1 = '{kind: KIND_TOKEND, ch: '0, line: r_tsl};
                                    tok_rst = 1'b1;
                                end
                            end
                        end
                        CH_LBRK: begin
                            d = (r_delim == DM_NONE || r_delim == DM_SPACE) ? DM_SQUARE
                                                                            : r_delim;
                            n_delim = d;
                            if (d != DM_BRACE && r_brk < DEPTH_W'(NEST_DEPTH)) begin
                                stk_push = 1'b1;
                                n_top = r_qpar;
                                n_brk = r_brk + 1'b1;
                            end
                        end
                        CH_RBRK: begin
                            d = (r_delim == DM_NONE) ? DM_SPACE : r_delim;
                            if (d != DM_BRACE && r_brk != '0 && r_top == r_qpar) begin
                                nb = r_brk - 1'b1;
                                n_top = r_below;
                            end
                            n_brk = nb;
                            if (d == DM_SQUARE && nb == '0) begin
                                d = DM_SPACE;
                            end
                            n_delim = d;
                        end
                        default: begin
                            if (r_delim == DM_NONE) begin
                                n_delim = DM_SPACE;
                            end
                        end
                    endcase
                end
            end
        end

        // per-token state back to idle after a token or statement end
        if (tok_rst) begin
            n_delim = DM_NONE;
            n_eat   = 1'b1;
            n_esc   = 1'b0;
            n_brace = '0;
            n_brk   = '0;
            n_qpar  = 1'b0;
            n_tnz   = 1'b0;
            n_tsl   = n_line;
        end

        if (i_cfg_wr_en) begin
            n_start = i_cfg_wr_data;
            n_line  = i_cfg_wr_data;
            n_tsl   = i_cfg_wr_data;
        end
    end

    assign stk_rd_addr = SADDR_W'(n_brk - DEPTH_W'(2));

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DM_NONE;
            r_eat   <= 1'b1;
            r_esc   <= 1'b0;
            r_brace <= '0;
            r_brk   <= '0;
            r_qpar  <= 1'b0;
            r_tnz   <= 1'b0;
            r_line  <= START_LINE_RST;
            r_tsl   <= START_LINE_RST;
            r_start <= START_LINE_RST;
        end else begin
            r_delim <= n_delim;
            r_eat   <= n_eat;
            r_esc   <= n_esc;
            r_brace <= n_brace;
            r_brk   <= n_brk;
            r_qpar  <= n_qpar;
            r_tnz   <= n_tnz;
            r_line  <= n_line;
            r_tsl   <= n_tsl;
            r_start <= n_start;
        end
    end

    // Stack memory; entry below the new top is read ahead for the next pop
    always_ff @(posedge i_clk) begin
        if (stk_push) begin
            mem_stk[r_brk[SADDR_W-1:0]] <= r_qpar;
        end
        r_below <= mem_stk[stk_rd_addr];
        r_top   <= n_top;
    end

    assign o_push = res_cnt_nz;
    assign o_pair = '{two: res_two, r0: res0, r1: res1};

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_depth_cap, i_clk, i_rst_n, r_brace <= DEPTH_W'(NEST_DEPTH) && r_brk <= DEPTH_W'(NEST_DEPTH), "nesting depth beyond limit")
    `ASSERT_NEXT(a_esc_silent, i_clk, i_rst_n, i_accept && !i_cmd && !r_esc && !r_eat && i_char == CH_BSL && !i_cfg_wr_en, r_esc && $stable(r_line), "backslash not held as pending escape")

endmodule

[rtl/tcl_tok_fifo.sv]
module tcl_tok_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tcl_tok_pkg::t_pair  i_pair,
    input  logic                i_pop,
    output tcl_tok_pkg::t_pair  o_head,
    output logic                o_empty,
    output logic                o_full
);
    import tcl_tok_pkg::*;

    t_pair            r_q [QUEUE_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_CW-1:0]  r_count, n_count;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CW'(QUEUE_DEPTH));
    assign o_head  = r_q[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_pair;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, i_push && !do_pop, r_count == $past(r_count) + 1'b1, "occupancy lost a push")

endmodule

[rtl/tcl_tok_back.sv]
module tcl_tok_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcl_tok_pkg::t_pair              i_head,
    input  logic                            i_empty,
    input  logic                            i_pop,
    output logic                            o_q_pop,
    output logic                            o_empty,
    output logic [1:0]                      o_kind,
    output logic [tcl_tok_pkg::CHAR_W-1:0]  o_char_out,
    output logic [tcl_tok_pkg::LINE_W-1:0]  o_line,
    output logic                            o_last
);
    import tcl_tok_pkg::*;

    // Which word of the head pair is shown
    logic  r_sel;
    t_res  cur;
    logic  take;

    assign cur        = r_sel ? i_head.r1 : i_head.r0;
    assign o_empty    = i_empty;
    assign o_kind     = cur.kind;
    assign o_char_out = cur.ch;
    assign o_line     = cur.line;
    assign o_last     = r_sel || !i_head.two;
    assign take       = i_pop && !i_empty;
    assign o_q_pop    = take && o_last;

    // Step through the pair, release it after its last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (take) begin
            r_sel <= !o_last;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_sel_two, i_clk, i_rst_n, !r_sel || (!i_empty && i_head.two), "second word shown without a pair")

endmodule

[rtl/tcl_word_tokenizer_top.sv]
// Tcl word tokenizer. Source bytes (i_cmd = 0) or an end-of-code command
// (i_cmd = 1) enter through a queue-style port (i_push / o_full); result words
// leave through another (o_empty / i_pop): token bytes, token ends and statement
// ends carrying the start line, and a final end-of-input mark. o_last marks the
// last result of each input word. One input word is taken every cycle while the
// four-entry result queue between the tokenizer and the output has room; each
// input gives zero, one or two results, and the output port delivers one result
// per cycle while i_pop is high, so once the queue fills, bytes that produce two
// results are taken no faster than the output drains them. The bracket quote
// stack is a 64-entry memory with its top cached in a register; nesting never
// stalls the input. start_line (reset 1) is written through i_cfg_wr_en /
// i_cfg_wr_data and reloads the line counter; the user writes it only while the
// block is idle (not enforced here). No clearing pass is needed after reset.
module tcl_word_tokenizer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_cmd,
    input  logic [tcl_tok_pkg::CHAR_W-1:0]  i_char_in,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [1:0]                      o_kind,
    output logic [tcl_tok_pkg::CHAR_W-1:0]  o_char_out,
    output logic [tcl_tok_pkg::LINE_W-1:0]  o_line,
    output logic                            o_last,
    input  logic                            i_cfg_wr_en,
    input  logic [tcl_tok_pkg::LINE_W-1:0]  i_cfg_wr_data
);
    import tcl_tok_pkg::*;

    logic   accept;
    logic   f_push;
    t_pair  f_pair;
    t_pair  q_head;
    logic   q_empty;
    logic   q_pop;

    assign accept = i_push && !o_full;

    // Tokenizer front
    tcl_tok_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_char        (i_char_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (f_push),
        .o_pair        (f_pair)
    );

    // Result queue
    tcl_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_pair  (f_pair),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (o_full)
    );

    // Output serializer
    tcl_tok_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_empty    (q_empty),
        .i_pop      (i_pop),
        .o_q_pop    (q_pop),
        .o_empty    (o_empty),
        .o_kind     (o_kind),
        .o_char_out (o_char_out),
        .o_line     (o_line),
        .o_last     (o_last)
    );

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcl_tok_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int MAX_REPORTS   = 10;

    // One expected result word plus its end-of-input-word flag
    typedef struct {
        t_res r;
        logic lst;
    } t_tok_word;

    // Predicts the result words of the tokenizer and checks the ones that come out
    class tok_result_board;
        logic [LINE_W-1:0] start_line;
        logic [LINE_W-1:0] line_cnt;
        logic [LINE_W-1:0] tok_line;
        t_delim            mode;
        bit                eat_sp;
        bit                esc;
        bit                tok_nonempty;
        bit                q_par;
        int unsigned       brace_dep;
        int unsigned       brack_dep;
        bit                brack_q [NEST_DEPTH];
        t_tok_word         step_out[$];
        t_tok_word         expected_words[$];
        int                fail_count;

        function new();
            fail_count = 0;
            start_line = START_LINE_RST;
            line_cnt   = start_line;
            foreach (brack_q[i]) brack_q[i] = 1'b0;
            tok_clear();
        endfunction

        function void load_start_line(input logic [LINE_W-1:0] v);
            start_line = v;
            line_cnt   = v;
            tok_line   = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void add(input t_kind k, input logic [CHAR_W-1:0] c,
                          input logic [LINE_W-1:0] ln);
            t_tok_word w;
            if (step_out.size() >= 2)
                return;
            w.r.kind = k;
            w.r.ch   = c;
            w.r.line = ln;
            w.lst    = 1'b0;
            step_out.push_back(w);
        endfunction

        function void emit_byte(input logic [CHAR_W-1:0] c);
            add(KIND_BYTE, c, '0);
            tok_nonempty = 1'b1;
        endfunction

        // Per-token state back to idle
        function void tok_clear();
            mode         = DM_NONE;
            eat_sp       = 1'b1;
            esc          = 1'b0;
            brace_dep    = 0;
            brack_dep    = 0;
            q_par        = 1'b0;
            tok_nonempty = 1'b0;
            tok_line     = line_cnt;
        endfunction

        function void close_token();
            add(KIND_TOKEND, '0, tok_line);
            tok_clear();
        endfunction

        function void close_stmt(input bit with_tok);
            if (with_tok)
                add(KIND_TOKEND, '0, tok_line);
            add(KIND_STMT, '0, tok_line);
            tok_clear();
        endfunction

        function void scan_byte(input logic [CHAR_W-1:0] c);
            if (eat_sp && (c == CH_SP || c == CH_TAB))
                return;
            if (c == CH_DEL)
                return;

            // Byte after a backslash
            if (esc) begin
                esc = 1'b0;
                if (c == CH_NL) begin
                    line_cnt = line_cnt + 1'b1;
                    if (eat_sp) begin
                        mode     = DM_NONE;
                        tok_line = line_cnt;
                    end else if (mode == DM_SPACE) begin
                        close_token();
                    end else begin
                        emit_byte(CH_BSL);
                        emit_byte(CH_NL);
                    end
                end else begin
                    emit_byte(CH_BSL);
                    emit_byte(c);
                    eat_sp = 1'b0;
                end
                return;
            end

            if (c == CH_BSL) begin
                esc = 1'b1;
                if (mode == DM_NONE)
                    mode = DM_SPACE;
                return;
            end

            eat_sp = 1'b0;

            if (mode == DM_COMMENT && c != CH_NL) begin
                emit_byte(c);
                return;
            end

            case (c)
                CH_HASH: begin
                    if (!tok_nonempty)
                        mode = DM_COMMENT;
                    emit_byte(c);
                end
                CH_NL, CH_SEMI: begin
                    if (c == CH_NL)
                        line_cnt = line_cnt + 1'b1;
                    if (mode == DM_NONE)
                        close_stmt(1'b0);
                    else if (mode == DM_SPACE || (mode == DM_COMMENT && c == CH_NL))
                        close_stmt(tok_nonempty);
                    else
                        emit_byte(c);
                end
                CH_SP, CH_TAB: begin
                    if (mode == DM_SPACE)
                        close_token();
                    else
                        emit_byte(c);
                end
                CH_DQ: begin
                    emit_byte(c);
                    q_par = ~q_par;
                    if (mode == DM_NONE)
                        mode = DM_QUOTE;
                    else if (mode == DM_QUOTE)
                        close_token();
                end
                CH_LBRACE: begin
                    emit_byte(c);
                    if (mode == DM_NONE)
                        mode = DM_BRACE;
                    if (mode == DM_BRACE && brace_dep < NEST_DEPTH)
                        brace_dep++;
                end
                CH_RBRACE: begin
                    emit_byte(c);
                    if (mode == DM_NONE)
                        mode = DM_SPACE;
                    if (mode == DM_BRACE) begin
                        if (brace_dep > 0)
                            brace_dep--;
                        if (brace_dep == 0)
                            close_token();
                    end
                end
                CH_LBRK: begin
                    emit_byte(c);
                    if (mode == DM_NONE || mode == DM_SPACE)
                        mode = DM_SQUARE;
                    if (mode != DM_BRACE && brack_dep < NEST_DEPTH) begin
                        brack_q[brack_dep] = q_par;
                        brack_dep++;
                    end
                end
                CH_RBRK: begin
                    emit_byte(c);
                    if (mode == DM_NONE)
                        mode = DM_SPACE;
                    // pop only if the quote state matches the one at the open
                    if (mode != DM_BRACE && brack_dep > 0 && brack_q[brack_dep-1] == q_par)
                        brack_dep--;
                    if (mode == DM_SQUARE && brack_dep == 0)
                        mode = DM_SPACE;
                end
                default: begin
                    emit_byte(c);
                    if (mode == DM_NONE)
                        mode = DM_SPACE;
                end
            endcase
        endfunction

        // Accepted input word: work out its results and queue them
        function void take_source_word(input logic cmd, input logic [CHAR_W-1:0] c);
            t_tok_word w;
            step_out.delete();
            if (cmd) begin
                if (tok_nonempty)
                    add(KIND_TOKEND, '0, tok_line);
                add(KIND_EOI, '0, tok_line);
                line_cnt = start_line;
                foreach (brack_q[i]) brack_q[i] = 1'b0;
                tok_clear();
            end else begin
                scan_byte(c);
            end
            if (step_out.size() > 0) begin
                w = step_out.pop_back();
                w.lst = 1'b1;
                step_out.push_back(w);
            end
            foreach (step_out[i]) expected_words.push_back(step_out[i]);
        endfunction

        function void match_result(input logic [1:0] k, input logic [CHAR_W-1:0] c,
                                   input logic [LINE_W-1:0] ln, input logic lst);
            t_tok_word want;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result word: kind=%0d ch=%02h line=%0d last=%0b",
                             k, c, ln, lst);
                return;
            end
            want = expected_words.pop_front();
            if (k !== want.r.kind || c !== want.r.ch || ln !== want.r.line
                    || lst !== want.lst) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $write("result mismatch: expected kind=%0d ch=%02h line=%0d last=%0b,",
                           want.r.kind, want.r.ch, want.r.line, want.lst);
                    $display(" got kind=%0d ch=%02h line=%0d last=%0b", k, c, ln, lst);
                end
            end
        endfunction

        // Anything still expected at the end is a miss
        function void close_out();
            if (expected_words.size() != 0) begin
                fail_count += expected_words.size();
                $display("%0d result words never came out", expected_words.size());
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_push        = 1'b0;
    logic              i_cmd         = 1'b0;
    logic [CHAR_W-1:0] i_char_in     = '0;
    logic              i_pop         = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [LINE_W-1:0] i_cfg_wr_data = '0;
    logic              o_full;
    logic              o_empty;
    logic [1:0]        o_kind;
    logic [CHAR_W-1:0] o_char_out;
    logic [LINE_W-1:0] o_line;
    logic              o_last;

    tok_result_board board = new();

    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          rx_hold_left = 0;
    int          src_count    = 0;
    int unsigned cycle_cnt    = 0;
    logic [8:0]  src_words[$];

    string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCXYZ0123456789_$.-+=*:";

    tcl_word_tokenizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_cmd         (i_cmd),
        .i_char_in     (i_char_in),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_kind        (o_kind),
        .o_char_out    (o_char_out),
        .o_line        (o_line),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** tcl_word_tokenizer_top: FAILED **");
            $finish;
        end
    end

    // Monitor: every handshake of both ports and the config write, in one place
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                board.load_start_line(i_cfg_wr_data);
            if (i_push && !o_full)
                board.take_source_word(i_cmd, i_char_in);
            if (i_pop && !o_empty)
                board.match_result(o_kind, o_char_out, o_line, o_last);
        end
    end

    // Result side: random pop with an optional long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_pop <= 1'b0;
                rx_hold_left--;
            end else begin
                i_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one word and wait until it is taken; push stays high on return
    task automatic send_word(input logic cmd, input logic [CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_push <= 1'b0;
        end
        @(negedge i_clk);
        i_push    <= 1'b1;
        i_cmd     <= cmd;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (cmd || c != CH_DEL)
            src_count++;
    endtask

    task automatic flush_src();
        logic [8:0] w;
        while (src_words.size() > 0) begin
            w = src_words.pop_front();
            send_word(w[8], w[7:0]);
        end
    endtask

    // Stop offering and wait until every expected word is out
    task automatic drain_results();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_start_line(input logic [LINE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic void put_src(input logic [CHAR_W-1:0] c);
        src_words.push_back({1'b0, c});
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_src(s[i]);
    endfunction

    function automatic void put_eoc();
        src_words.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void put_blank();
        put_src($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endfunction

    // Plain word, now and then with a high byte
    function automatic void gen_word();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 11) == 0)
                put_src(8'($urandom_range(128, 255)));
            else
                put_src(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
        end
    endfunction

    // Braced or bracketed group with random, mostly balanced content
    function automatic void gen_group(input logic [CHAR_W-1:0] op, input logic [CHAR_W-1:0] cl);
        int depth;
        int n;
        depth = 1;
        put_src(op);
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gen_word();
                3: put_blank();
                4: put_src(CH_NL);
                5: if (depth < 4) begin
                    put_src(op);
                    depth++;
                end
                6: if (depth > 1) begin
                    put_src(cl);
                    depth--;
                end
                7: begin
                    put_src(CH_DQ);
                    gen_word();
                    put_src(CH_DQ);
                end
                8: if (op == CH_LBRACE) begin
                    put_src(CH_LBRK);
                    gen_word();
                    put_src(CH_RBRK);
                end else begin
                    put_src(CH_LBRACE);
                    gen_word();
                    put_src(CH_RBRACE);
                end
                default: begin
                    put_src(CH_BSL);
                    case ($urandom_range(0, 3))
                        0: put_src(CH_NL);
                        1: put_src(CH_DQ);
                        2: put_src(cl);
                        default: gen_word();
                    endcase
                end
            endcase
        end
        repeat (depth) put_src(cl);
    endfunction

    function automatic void gen_quoted();
        int n;
        put_src(CH_DQ);
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: gen_word();
                1: put_blank();
                2: begin
                    put_src(CH_LBRK);
                    gen_word();
                    put_src(CH_RBRK);
                end
                default: begin
                    put_src(CH_BSL);
                    put_src($urandom_range(0, 1) ? CH_DQ : CH_NL);
                end
            endcase
        end
        put_src(CH_DQ);
    endfunction

    // One command line, sometimes a comment, with noise and end of code now and then
    function automatic void gen_stmt();
        int nargs;
        if ($urandom_range(0, 9) == 0) begin
            put_src(CH_HASH);
            gen_word();
            put_blank();
            gen_word();
            put_src(CH_NL);
        end else begin
            if ($urandom_range(0, 3) == 0)
                put_blank();
            gen_word();
            nargs = $urandom_range(0, 4);
            repeat (nargs) begin
                if ($urandom_range(0, 7) == 0) begin
                    put_src(CH_BSL);
                    put_src(CH_NL);
                end else begin
                    put_blank();
                end
                case ($urandom_range(0, 4))
                    0, 1: gen_word();
                    2: gen_group(CH_LBRACE, CH_RBRACE);
                    3: gen_group(CH_LBRK, CH_RBRK);
                    default: gen_quoted();
                endcase
            end
            case ($urandom_range(0, 5))
                0: put_src(CH_SEMI);
                1: ;
                default: put_src(CH_NL);
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) put_src(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                put_src(CH_DEL);
        end
        if ($urandom_range(0, 24) == 0)
            put_eoc();
    endfunction

    // Nesting past the depth limit, braces or brackets
    function automatic void gen_deep();
        logic [CHAR_W-1:0] op;
        logic [CHAR_W-1:0] cl;
        int n;
        op = $urandom_range(0, 1) ? CH_LBRACE : CH_LBRK;
        cl = (op == CH_LBRACE) ? CH_RBRACE : CH_RBRK;
        n  = $urandom_range(NEST_DEPTH + 1, NEST_DEPTH + 3);
        put_text("set ");
        repeat (n) put_src(op);
        gen_word();
        repeat (n) put_src(cl);
        put_src(CH_NL);
    endfunction

    task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = src_count + n_items;
        gen_deep();
        flush_src();
        while (src_count < target) begin
            gen_stmt();
            flush_src();
        end
        put_eoc();
        flush_src();
        drain_results();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: blanks before a token, escaped newlines, odd bytes, marks
        put_text(" \t\\ \n");
        put_text("a\\\n");
        put_src(CH_RBRK);
        put_src(8'h00);
        put_src(CH_DEL);
        put_src(8'hff);
        put_text(" \"q\" {};#x\nb\\");
        put_eoc();
        flush_src();
        drain_results();

        load_start_line('1);
        run_phase(22, 65, 310);

        load_start_line('0);
        run_phase(65, 22, 310);

        load_start_line(LINE_W'($urandom_range(2, 1048574)));
        @(posedge i_clk);
        rx_hold_left = HOLD_CYCLES;
        run_phase(0, 0, 310);

        board.close_out();
        if (board.fail_count == 0)
            $display("** tcl_word_tokenizer_top: PASSED **");
        else
            $display("** tcl_word_tokenizer_top: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tcl_tok_pkg.sv
rtl/tcl_tok_front.sv
rtl/tcl_tok_fifo.sv
rtl/tcl_tok_back.sv
rtl/tcl_word_tokenizer_top.sv
tb/sv/tb.sv
